// ===== rtl/ast_pkg.sv =====
// Shared types, constants and helper functions of the assembly source tokenizer.
// No dependencies; imported by every module of the block except ast_ram.
package ast_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 32;

  // Character codes the tokenizer reacts to
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_INT   = 2'd1,
    PK_IDENT = 2'd2,
    PK_REG   = 2'd3
  } pend_kind_t;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_OP    = 3'd1,
    KIND_IDENT = 3'd2,
    KIND_LABEL = 3'd3,
    KIND_REG   = 3'd4
  } tok_kind_t;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_PUNCT,
    CC_COLON,
    CC_SPACE,
    CC_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    POST_NONE,
    POST_OP,
    POST_START
  } post_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_OP,
    ST_START
  } state_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tok_char;
    logic [2:0] tok_kind;
    logic       tok_last;
    logic       tok_truncated;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       append;
    logic       set_kind;
    pend_kind_t new_kind;
    logic       emit_start;
    logic       rd_en;
    logic       out_load;
    logic       out_op;
    tok_kind_t  emit_kind;
    logic       advance;
    logic       clear_tok;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic        eot;
    char_class_t cls;
    logic        is_r;
    pend_kind_t  kind;
    logic        out_free;
    logic        emit_last;
  } dp_sts_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      cls = CC_DIGIT;
    end else if (c == CH_HASH || c == CH_COMMA) begin
      cls = CC_PUNCT;
    end else if (c == CH_COLON) begin
      cls = CC_COLON;
    end else if (c == CH_SPACE || c == CH_NL) begin
      cls = CC_SPACE;
    end else begin
      cls = CC_OTHER;
    end
    return cls;
  endfunction

  function automatic tok_kind_t pend_to_tok(input pend_kind_t k);
    tok_kind_t t;
    unique case (k)
      PK_INT:   t = KIND_INT;
      PK_IDENT: t = KIND_IDENT;
      PK_REG:   t = KIND_REG;
      default:  t = KIND_INT;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/assembly_source_tokenizer_top.sv =====
// Top level of the assembly source tokenizer: controller plus datapath.
// Depends on ast_pkg, ast_ctrl, ast_dpath (and ast_ram below it).
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word per source
//   character; end_of_text set flushes the pending token and ignores in_char.
//   Result channel (out_valid/out_ready/out_data) delivers one word per token
//   character with its kind, a last mark and a truncation flag.
//   Tokens longer than MAX_TOKEN_LEN keep their first MAX_TOKEN_LEN characters
//   and carry tok_truncated on every delivered word.
// Sequencing:
//   A word is taken, then decoded in the next cycle. Emitting a token takes
//   a buffer RAM read, then an output register load, per character; a
//   trailing operator load or the start of the next token follows in a
//   state of its own. The buffer RAM's single read port and registered
//   read set this read-then-load order for each character.
// Reset (rst_n low, synchronous) clears the pending token and the output
// register; the buffer RAM needs no clearing. When the receiver stalls, the
// result word holds in the output register and emission pauses; in_ready
// stays low until the current word has been fully handled.
module assembly_source_tokenizer_top
  import ast_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequence decode and emission
  ast_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Hold the token buffer and drive the result register
  ast_dpath #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/ast_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ast_dpath.sv =====
// Tokenizer datapath: held input word, token buffer RAM, length, kind, overflow,
// read index and output register. Depends on ast_pkg and ast_ram.
module ast_dpath
  import ast_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  ctl_cmd_t  cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IW = $clog2(MAX_TOKEN_LEN);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LEN);

  logic [7:0]  char_r, char_nxt;
  logic        eot_r, eot_nxt;
  pend_kind_t  kind_r, kind_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic        ovf_r, ovf_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic        room;
  logic        emit_last;
  logic [7:0]  rd_data;

  assign room      = len_r < MAX_LEN;
  assign emit_last = LW'(idx_r + LW'(1)) == len_r;

  ast_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TOKEN_LEN)
  ) u_buf (
    .clk    (clk),
    .wr_en  (cmd.append && room),
    .wr_addr(len_r[IW-1:0]),
    .wr_data(char_r),
    .rd_en  (cmd.rd_en),
    .rd_addr(idx_r[IW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    char_nxt      = char_r;
    eot_nxt       = eot_r;
    kind_nxt      = kind_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.capture) begin
      char_nxt = in_data.in_char;
      eot_nxt  = in_data.end_of_text;
    end

    if (cmd.clear_tok) begin
      kind_nxt = PK_NONE;
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
    end

    if (cmd.append) begin
      if (room) begin
        len_nxt = LW'(len_r + LW'(1));
      end else begin
        ovf_nxt = 1'b1;
      end
      if (cmd.set_kind) begin
        kind_nxt = cmd.new_kind;
      end
    end

    if (cmd.emit_start) begin
      idx_nxt = '0;
    end else if (cmd.advance) begin
      idx_nxt = LW'(idx_r + LW'(1));
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      if (cmd.out_op) begin
        out_data_nxt.tok_char      = char_r;
        out_data_nxt.tok_kind      = KIND_OP;
        out_data_nxt.tok_last      = 1'b1;
        out_data_nxt.tok_truncated = 1'b0;
      end else begin
        out_data_nxt.tok_char      = rd_data;
        out_data_nxt.tok_kind      = cmd.emit_kind;
        out_data_nxt.tok_last      = emit_last;
        out_data_nxt.tok_truncated = ovf_r;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eot_r       <= 1'b0;
      kind_r      <= PK_NONE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      eot_r       <= eot_nxt;
      kind_r      <= kind_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.eot       = eot_r;
  assign sts.cls       = classify(char_r);
  assign sts.is_r      = char_r == CH_R;
  assign sts.kind      = kind_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_last = emit_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= MAX_LEN)
    else $error("token length beyond buffer size");

  a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == PK_NONE) == (len_r == '0))
    else $error("pending kind and length disagree");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (idx_r < len_r))
    else $error("buffer read past token end");
`endif

endmodule

// ===== rtl/ast_ctrl.sv =====
// Tokenizer controller: decodes each held word and sequences token emission.
// Depends on ast_pkg; drives ast_dpath through ctl_cmd_t.
module ast_ctrl
  import ast_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t     state_r, state_nxt;
  tok_kind_t  emit_kind_r, emit_kind_nxt;
  post_t      post_r, post_nxt;

  // Decode of the held word
  logic       dec_append;
  logic       dec_set_kind;
  pend_kind_t dec_new_kind;
  logic       dec_emit;
  tok_kind_t  dec_emit_kind;
  post_t      dec_post;
  pend_kind_t new_id;
  logic       flush;

  assign new_id = sts.is_r ? PK_REG : PK_IDENT;
  assign flush  = sts.kind != PK_NONE;

  always_comb begin
    dec_append    = 1'b0;
    dec_set_kind  = 1'b0;
    dec_new_kind  = new_id;
    dec_emit      = 1'b0;
    dec_emit_kind = pend_to_tok(sts.kind);
    dec_post      = POST_NONE;
    if (sts.eot) begin
      dec_emit = flush;
    end else begin
      unique case (sts.cls)
        CC_DIGIT: begin
          dec_append   = 1'b1;
          dec_set_kind = !flush;
          dec_new_kind = PK_INT;
        end
        CC_PUNCT: begin
          dec_emit = flush;
          dec_post = POST_OP;
        end
        CC_COLON: begin
          if (sts.kind == PK_IDENT) begin
            dec_append    = 1'b1;
            dec_emit      = 1'b1;
            dec_emit_kind = KIND_LABEL;
          end else begin
            dec_emit = flush;
            dec_post = POST_OP;
          end
        end
        CC_SPACE: begin
          dec_emit = flush;
        end
        default: begin
          if (sts.kind == PK_NONE) begin
            dec_append   = 1'b1;
            dec_set_kind = 1'b1;
          end else if (sts.kind == PK_INT) begin
            dec_emit = 1'b1;
            dec_post = POST_START;
          end else begin
            dec_append = 1'b1;
          end
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    emit_kind_nxt = emit_kind_r;
    post_nxt      = post_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        emit_kind_nxt = dec_emit_kind;
        post_nxt      = dec_post;
        if (dec_emit) begin
          state_nxt = ST_EMIT_RD;
        end else if (dec_post == POST_OP) begin
          state_nxt = ST_OP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts.out_free) begin
          if (!sts.emit_last) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            unique case (post_r)
              POST_OP:    state_nxt = ST_OP;
              POST_START: state_nxt = ST_START;
              default:    state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_OP: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd           = '0;
    cmd.new_kind  = dec_new_kind;
    cmd.emit_kind = emit_kind_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        cmd.append     = dec_append;
        cmd.set_kind   = dec_set_kind;
        cmd.emit_start = dec_emit;
      end
      ST_EMIT_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_EMIT_WR: begin
        cmd.out_load  = sts.out_free;
        cmd.advance   = sts.out_free && !sts.emit_last;
        cmd.clear_tok = sts.out_free && sts.emit_last;
      end
      ST_OP: begin
        cmd.out_load = sts.out_free;
        cmd.out_op   = 1'b1;
      end
      ST_START: begin
        cmd.append   = 1'b1;
        cmd.set_kind = 1'b1;
        cmd.new_kind = new_id;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_kind_r <= KIND_INT;
      post_r      <= POST_NONE;
    end else begin
      state_r     <= state_nxt;
      emit_kind_r <= emit_kind_nxt;
      post_r      <= post_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |-> (sts.kind == PK_NONE))
    else $error("new token started over a pending one");

  a_decode_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE) |-> $past(in_valid && in_ready))
    else $error("decode without an accepted word");
`endif

endmodule
